// ===== rtl/tprc_pkg.sv =====
// Shared types and constants for the touch report palm classifier.
`default_nettype none

package tprc_pkg;

    localparam int MAX_CONTACTS = 5;
    localparam int REPORT_BYTES = 16;
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    localparam logic [7:0] TOUCH_REPORT_ID = 8'h04;
    localparam logic [4:0] POS_SATURATE = 5'd31;

    // byte offsets inside a report
    localparam logic [4:0] POS_ID      = 5'd0;
    localparam logic [4:0] POS_FLAGS   = 5'd1;
    localparam logic [4:0] POS_X_LO    = 5'd2;
    localparam logic [4:0] POS_X_HI    = 5'd3;
    localparam logic [4:0] POS_Y_LO    = 5'd4;
    localparam logic [4:0] POS_Y_HI    = 5'd5;
    localparam logic [4:0] POS_COUNT   = 5'd8;
    localparam logic [4:0] POS_BTNSIZE = 5'd9;
    localparam logic [4:0] POS_PRES_LO = 5'd14;
    localparam logic [4:0] POS_PRES_HI = 5'd15;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_FINGER = 2'd1;
    localparam logic [1:0] KIND_PALM   = 2'd2;

    localparam logic [0:0] REG_PALM_SIZE  = 1'b0;
    localparam logic [0:0] REG_PALM_PRESS = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  contact_id;
        logic [1:0]  tool_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [6:0]  touch_size;
        logic [15:0] touch_pressure;
        logic        frame_end;
        logic        button_down;
    } out_item_t;

    // classified contact handed from the front to the back
    typedef struct packed {
        logic [3:0]  contact_id;
        logic [1:0]  tool_kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [6:0]  touch_size;
        logic [15:0] touch_pressure;
        logic [7:0]  count_byte;
        logic        button_bit;
    } req_t;

    typedef struct packed {
        logic [6:0]  size_limit;
        logic [15:0] pressure_limit;
    } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/touch_report_palm_classifier.sv =====
// A report's contact enters the request queue as its last byte is accepted, then the result queue.
// Throughput: one byte per cycle while the request queue (parser to frame tracker) has room;
//   a result queue decouples the result side, so stalls there only block once both fill.
// Only reports of at least 16 bytes give a contact, so results come at most one per 16 bytes.
// Reset: rst_n is asynchronous, active low; clears byte position, captured fields, frame
//   state, queues and both palm limits.
`default_nettype none

module touch_report_palm_classifier
    import tprc_pkg::*;
#(
    parameter int MID_DEPTH = MID_DEPTH_DEF,
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire in_item_t    item,
    output logic             full,
    input  wire logic        pop,
    output out_item_t        result,
    output logic             empty,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t      cfg_reg, cfg_next;
    logic      in_accept;
    logic      req_valid, req_empty, req_pop;
    req_t      front_req;
    logic [$bits(req_t)-1:0] mid_rdata;
    logic      res_full, res_push;
    out_item_t back_res;
    logic [$bits(out_item_t)-1:0] out_rdata;
    logic      cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign in_accept = push && !full;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (paddr[2])
                REG_PALM_SIZE:  cfg_next.size_limit     = pwdata[6:0];
                REG_PALM_PRESS: cfg_next.pressure_limit = pwdata[15:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_PALM_SIZE:  prdata = {25'd0, cfg_reg.size_limit};
            REG_PALM_PRESS: prdata = {16'd0, cfg_reg.pressure_limit};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tprc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .item      (item),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (front_req)
    );

    // input stalls on the request queue only
    tprc_fifo #(
        .DEPTH (MID_DEPTH),
        .WIDTH ($bits(req_t))
    ) u_req_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (req_valid),
        .wdata (front_req),
        .pop   (req_pop),
        .rdata (mid_rdata),
        .full  (full),
        .empty (req_empty)
    );

    tprc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_empty (req_empty),
        .req       (req_t'(mid_rdata)),
        .res_full  (res_full),
        .req_pop   (req_pop),
        .res_push  (res_push),
        .res       (back_res)
    );

    tprc_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH ($bits(out_item_t))
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .pop   (pop),
        .rdata (out_rdata),
        .full  (res_full),
        .empty (empty)
    );

    assign result = out_item_t'(out_rdata);

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result queue written while full");

    a_no_req_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !item.last_byte) |-> !req_valid)
        else $error("contact request raised before end of report");

    a_inactive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.tool_kind == KIND_NONE) |->
        (result.pos_x == '0 && result.pos_y == '0 && result.touch_size == '0 &&
         result.touch_pressure == '0))
        else $error("inactive contact carries nonzero fields");

    a_button_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.button_down) |-> result.frame_end)
        else $error("button bit outside frame end");

endmodule

`default_nettype wire

// ===== rtl/tprc_fifo.sv =====
// Small flip-flop queue with registered status, one push and one pop per cycle.
`default_nettype none

module tprc_fifo
    import tprc_pkg::*;
#(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             pop,
    output logic      [WIDTH-1:0] rdata,
    output logic                  full,
    output logic                  empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tprc_front.sv =====
// Report parser: captures report bytes and classifies each accepted contact.
`default_nettype none

module tprc_front
    import tprc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    input  wire cfg_t     cfg,
    output logic          req_valid,
    output req_t          req
);

    logic [4:0]  pos_reg, pos_next;
    logic        id_reg, id_next;
    logic [7:0]  flag_reg, flag_next;
    logic [15:0] x_reg, x_next;
    logic [15:0] y_reg, y_next;
    logic [7:0]  count_reg, count_next;
    logic [7:0]  bsize_reg, bsize_next;
    logic [15:0] pres_reg, pres_next;

    logic [7:0]  b;
    logic [6:0]  size;
    logic        active, palm, long_enough;

    assign b = item.data_byte;

    always_comb
    begin
        id_next    = id_reg;
        flag_next  = flag_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        count_next = count_reg;
        bsize_next = bsize_reg;
        pres_next  = pres_reg;
        case (pos_reg)
            POS_ID:      id_next    = (b == TOUCH_REPORT_ID);
            POS_FLAGS:   flag_next  = b;
            POS_X_LO:    x_next     = {x_reg[15:8], b};
            POS_X_HI:    x_next     = {b, x_reg[7:0]};
            POS_Y_LO:    y_next     = {y_reg[15:8], b};
            POS_Y_HI:    y_next     = {b, y_reg[7:0]};
            POS_COUNT:   count_next = b;
            POS_BTNSIZE: bsize_next = b;
            POS_PRES_LO: pres_next  = {pres_reg[15:8], b};
            POS_PRES_HI: pres_next  = {b, pres_reg[7:0]};
            default:     ;
        endcase

        if (item.last_byte)
        begin
            pos_next = '0;
        end
        else if (pos_reg < POS_SATURATE)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    // classification works on the values as they stand after this byte
    always_comb
    begin
        size        = bsize_next[7:1];
        active      = flag_next[1] && flag_next[0];
        long_enough = (pos_reg >= 5'(REPORT_BYTES - 1));
        palm        = ((cfg.size_limit != '0) && (size >= cfg.size_limit)) ||
                      ((cfg.pressure_limit != '0) && (pres_next >= cfg.pressure_limit));

        req_valid  = accept && item.last_byte && id_next && long_enough;

        req.contact_id     = flag_next[7:4];
        req.count_byte     = count_next;
        req.button_bit     = bsize_next[0];
        req.tool_kind      = KIND_NONE;
        req.pos_x          = '0;
        req.pos_y          = '0;
        req.touch_size     = '0;
        req.touch_pressure = '0;
        if (active)
        begin
            req.tool_kind      = palm ? KIND_PALM : KIND_FINGER;
            req.pos_x          = x_next;
            req.pos_y          = y_next;
            req.touch_size     = size;
            req.touch_pressure = pres_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            id_reg    <= 1'b0;
            flag_reg  <= '0;
            x_reg     <= '0;
            y_reg     <= '0;
            count_reg <= '0;
            bsize_reg <= '0;
            pres_reg  <= '0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            flag_reg  <= flag_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            count_reg <= count_next;
            bsize_reg <= bsize_next;
            pres_reg  <= pres_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tprc_back.sv =====
// Frame tracker: counts contacts down per frame and forms the result.
`default_nettype none

module tprc_back
    import tprc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_empty,
    input  wire req_t req,
    input  wire logic res_full,
    output logic      req_pop,
    output logic      res_push,
    output out_item_t res
);

    logic [2:0] left_reg, left_next;
    logic       frame_reg, frame_next;
    logic [2:0] start_cnt, cur_left;
    logic       fend;

    assign req_pop  = !req_empty && !res_full;
    assign res_push = req_pop;

    always_comb
    begin
        if ((req.count_byte == '0) || (req.count_byte > 8'(MAX_CONTACTS)))
        begin
            start_cnt = 3'd1;
        end
        else
        begin
            start_cnt = req.count_byte[2:0];
        end

        cur_left   = frame_reg ? left_reg : start_cnt;
        left_next  = (cur_left != '0) ? cur_left - 1'b1 : cur_left;
        fend       = (left_next == '0);
        frame_next = !fend;

        res.contact_id     = req.contact_id;
        res.tool_kind      = req.tool_kind;
        res.pos_x          = req.pos_x;
        res.pos_y          = req.pos_y;
        res.touch_size     = req.touch_size;
        res.touch_pressure = req.touch_pressure;
        res.frame_end      = fend;
        res.button_down    = fend && req.button_bit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            frame_reg <= 1'b0;
        end
        else if (req_pop)
        begin
            left_reg  <= left_next;
            frame_reg <= frame_next;
        end
    end

endmodule

`default_nettype wire
